>>> sv/a1crp_pkg.sv
// Shared types and constants of the A1 cell reference parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package a1crp_pkg;

    localparam int CH_W    = 8;
    localparam int ROW_W   = 21;
    localparam int COL_W   = 15;
    localparam int LCNT_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ROW_W;

    localparam logic [ROW_W-1:0] MAX_ROW_RST = ROW_W'(1048576);
    localparam logic [COL_W-1:0] MAX_COL_RST = COL_W'(16384);
    localparam logic [ROW_W-1:0] ROW_SAT     = {ROW_W{1'b1}};
    localparam logic [COL_W-1:0] COL_RADIX   = COL_W'(26);
    localparam logic [ROW_W+3:0] ROW_RADIX   = (ROW_W + 4)'(10);
    localparam logic [LCNT_W-1:0] MAX_LETTERS = LCNT_W'(3);

    localparam logic [CH_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ROW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COL = 2'd1;

    typedef enum logic [4:0] {
        PH_START      = 5'b00001,
        PH_COL_DOLLAR = 5'b00010,
        PH_LETTERS    = 5'b00100,
        PH_ROW_DOLLAR = 5'b01000,
        PH_DIGITS     = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [LCNT_W-1:0]  letter_count;
        logic [COL_W-1:0]   column_acc;
        logic [ROW_W-1:0]   row_acc;
        logic               row_overflow;
        logic               dollar_col;
        logic               dollar_row;
        logic               failed;
    } ident_t;

    typedef struct packed {
        logic               valid_res;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
        logic               abs_column;
        logic               abs_row;
    } result_t;

    localparam ident_t IDENT_CLEAR = '{
        phase:        PH_START,
        letter_count: '0,
        column_acc:   '0,
        row_acc:      '0,
        row_overflow: 1'b0,
        dollar_col:   1'b0,
        dollar_row:   1'b0,
        failed:       1'b0
    };

endpackage

>>> sv/a1crp_char_step.sv
// Per-character update of the identifier state and the result on the last character.
// Pure combinational; uses a1crp_pkg.
`timescale 1ns / 1ps

module a1crp_char_step (
    input  a1crp_pkg::ident_t                cur,
    input  logic [a1crp_pkg::CH_W-1:0]       ch,
    input  logic                             last,
    input  logic [a1crp_pkg::ROW_W-1:0]      max_row,
    input  logic [a1crp_pkg::COL_W-1:0]      max_column,
    output a1crp_pkg::ident_t                nxt,
    output a1crp_pkg::result_t               result
);
    import a1crp_pkg::*;

    logic             is_letter;
    logic             is_digit;
    logic             is_dollar;
    logic             is_nz_digit;
    logic [ROW_W+3:0] row_wide;
    logic [COL_W-1:0] col_new;
    ident_t           s;
    logic             ok;

    assign is_letter = ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z))
                    || ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z));
    assign is_digit    = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_dollar   = (ch == CH_DOLLAR);
    assign is_nz_digit = is_digit && (ch != CH_ZERO);

    // letters map to 1..26 through their low five bits, digits through the low four
    assign col_new  = COL_W'(cur.column_acc * COL_RADIX + {{(COL_W-5){1'b0}}, ch[4:0]});
    assign row_wide = {4'b0000, cur.row_acc} * ROW_RADIX + {{ROW_W{1'b0}}, ch[3:0]};

    always_comb
    begin
        logic take_letter;
        logic take_digit;
        take_letter = 1'b0;
        take_digit  = 1'b0;
        s = cur;
        if (!cur.failed)
        begin
            unique case (cur.phase)
                PH_START:
                begin
                    if (is_dollar)
                    begin
                        s.dollar_col = 1'b1;
                        s.phase      = PH_COL_DOLLAR;
                    end
                    else if (is_letter) take_letter = 1'b1;
                    else s.failed = 1'b1;
                end
                PH_COL_DOLLAR:
                begin
                    if (is_letter) take_letter = 1'b1;
                    else s.failed = 1'b1;
                end
                PH_LETTERS:
                begin
                    if (is_letter) take_letter = 1'b1;
                    else if (is_dollar)
                    begin
                        s.dollar_row = 1'b1;
                        s.phase      = PH_ROW_DOLLAR;
                    end
                    else if (is_nz_digit) take_digit = 1'b1;
                    else s.failed = 1'b1;
                end
                PH_ROW_DOLLAR:
                begin
                    if (is_nz_digit) take_digit = 1'b1;
                    else s.failed = 1'b1;
                end
                PH_DIGITS:
                begin
                    if (is_digit) take_digit = 1'b1;
                    else s.failed = 1'b1;
                end
                default: s.failed = 1'b1;
            endcase
        end

        if (take_letter)
        begin
            if (cur.letter_count >= MAX_LETTERS)
                s.failed = 1'b1;
            else
            begin
                s.letter_count = cur.letter_count + LCNT_W'(1);
                s.column_acc   = col_new;
                s.phase        = PH_LETTERS;
            end
        end

        if (take_digit)
        begin
            if (row_wide > {4'b0000, ROW_SAT})
            begin
                s.row_acc      = ROW_SAT;
                s.row_overflow = 1'b1;
            end
            else
                s.row_acc = row_wide[ROW_W-1:0];
            s.phase = PH_DIGITS;
        end

        ok = !s.failed && (s.phase == PH_DIGITS) && !s.row_overflow
          && (s.row_acc != '0) && (s.row_acc <= max_row)
          && (s.column_acc != '0) && (s.column_acc <= max_column);

        result.valid_res  = ok;
        result.row        = ok ? s.row_acc : '0;
        result.column     = ok ? s.column_acc : '0;
        result.abs_column = ok && s.dollar_col;
        result.abs_row    = ok && s.dollar_row;

        nxt = last ? IDENT_CLEAR : s;
    end

endmodule

>>> sv/a1_cell_reference_parser_top.sv
// Top level of the A1 cell reference parser: limit registers, identifier state,
// result register with skid stage. Uses a1crp_pkg and a1crp_char_step.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid / in_stall, fields ch and last) takes one character
//   per item; last flags the final character of an identifier. Every cycle
//   without in_stall can carry a character: throughput is one item per cycle
//   unless stalled, set by the single state update between the identifier registers.
//   Output channel (out_valid / out_stall) gives one result item per identifier,
//   registered once its last character is accepted, via the skid stage if stalled.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 writes
//   max_row, index 1 writes max_column from cfg_data[14:0]; other indexes are
//   ignored. cfg_ready is always high. Write only while the block is idle.
//   Reset: limits return to 1048576 rows and 16384 columns, the parser is at
//   the start of an identifier and no result is pending.
//   Stall: a result held by out_stall stays stable; one more result fits in
//   the skid stage, after which in_stall rises until the output drains.
//
module a1_cell_reference_parser_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [a1crp_pkg::CH_W-1:0]           ch,
    input  logic                                 last,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 valid_res,
    output logic [a1crp_pkg::ROW_W-1:0]          row,
    output logic [a1crp_pkg::COL_W-1:0]          column,
    output logic                                 abs_column,
    output logic                                 abs_row,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [a1crp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [a1crp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import a1crp_pkg::*;

    logic [ROW_W-1:0] max_row_reg;
    logic [COL_W-1:0] max_col_reg;
    ident_t           ident_reg;
    ident_t           ident_next;
    result_t          step_res;
    result_t          out_reg;
    result_t          skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             in_acc;
    logic             res_new;
    logic             out_free;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_acc    = in_valid && !in_stall;
    assign res_new   = in_acc && last;
    assign out_free  = !out_valid_reg || !out_stall;

    a1crp_char_step u_step (
        .cur        (ident_reg),
        .ch         (ch),
        .last       (last),
        .max_row    (max_row_reg),
        .max_column (max_col_reg),
        .nxt        (ident_next),
        .result     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_row_reg <= MAX_ROW_RST;
            max_col_reg <= MAX_COL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAX_ROW: max_row_reg <= cfg_data;
                REG_MAX_COL: max_col_reg <= cfg_data[COL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ident_reg <= IDENT_CLEAR;
        else if (in_acc)
            ident_reg <= ident_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= res_new;
        end
        else if (res_new)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (res_new)
                out_reg <= step_res;
        end
        else if (res_new)
            skid_reg <= step_res;
    end

    assign out_valid  = out_valid_reg;
    assign valid_res  = out_reg.valid_res;
    assign row        = out_reg.row;
    assign column     = out_reg.column;
    assign abs_column = out_reg.abs_column;
    assign abs_row    = out_reg.abs_row;

endmodule

>>> sv/a1crp_checker.sv
// Port-level checks of the A1 cell reference parser, bound to the top level.
// Uses a1crp_pkg for widths.
`timescale 1ns / 1ps

module a1crp_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic                                 last,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic                                 valid_res,
    input  logic [a1crp_pkg::ROW_W-1:0]          row,
    input  logic [a1crp_pkg::COL_W-1:0]          column,
    input  logic                                 abs_column,
    input  logic                                 abs_row
);
    import a1crp_pkg::*;

    // a fresh result only follows an accepted last character
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid ##1 out_valid |-> $past(in_valid && !in_stall && last))
        else $error("result without a last character");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> (row == '0) && (column == '0) && !abs_column && !abs_row)
        else $error("invalid result carries nonzero fields");

    a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> (row != '0) && (column != '0))
        else $error("valid result with zero row or column");

    // input backs up only behind a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
        else $error("input stalled without output backpressure");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(valid_res) && $stable(row)
            && $stable(column) && $stable(abs_column) && $stable(abs_row))
        else $error("stalled result changed");

endmodule

bind a1_cell_reference_parser_top a1crp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .valid_res  (valid_res),
    .row        (row),
    .column     (column),
    .abs_column (abs_column),
    .abs_row    (abs_row)
);

>>> test/a1_cell_reference_parser_check.sv
// Checker for the A1 cell reference parser: watches the character, result and
// limit-write channels, predicts each result and compares it field by field.
// Depends on a1crp_pkg; instantiated by a1_cell_reference_parser_top_tb.
`timescale 1ns / 1ps

module a1_cell_reference_parser_check (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [a1crp_pkg::CH_W-1:0]           ch,
    input  logic                                 last,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic                                 valid_res,
    input  logic [a1crp_pkg::ROW_W-1:0]          row,
    input  logic [a1crp_pkg::COL_W-1:0]          column,
    input  logic                                 abs_column,
    input  logic                                 abs_row,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [a1crp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [a1crp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                   mismatch_count,
    output int                                   refs_pending
);
    import a1crp_pkg::*;

    localparam logic [CH_W-1:0] CASE_BIT = 8'h20;
    localparam int MAX_LETTER_COUNT = 3;

    phase_t           ph;
    logic [2:0]       n_letters;
    logic [COL_W-1:0] col_acc;
    logic [ROW_W-1:0] row_acc;
    logic             row_ovf;
    logic             dol_col;
    logic             dol_row;
    logic             bad;
    logic [ROW_W-1:0] row_lim;
    logic [COL_W-1:0] col_lim;
    result_t          expected_refs[$];
    result_t          want;
    int               errs;

    task automatic clear_ident;
        ph = PH_START;
        n_letters = '0;
        col_acc = '0;
        row_acc = '0;
        row_ovf = 1'b0;
        dol_col = 1'b0;
        dol_row = 1'b0;
        bad = 1'b0;
    endtask

    task automatic add_letter(input logic [CH_W-1:0] c);
        if (n_letters >= MAX_LETTER_COUNT) begin
            bad = 1'b1;
            return;
        end
        n_letters++;
        col_acc = COL_W'(int'(col_acc) * 26 + int'((c & ~CASE_BIT) - CH_UPPER_A) + 1);
        ph = PH_LETTERS;
    endtask

    task automatic add_digit(input logic [CH_W-1:0] c);
        int acc;
        acc = int'(row_acc) * 10 + int'(c - CH_ZERO);
        if (acc > int'(ROW_SAT)) begin
            acc = int'(ROW_SAT);
            row_ovf = 1'b1;
        end
        row_acc = ROW_W'(acc);
        ph = PH_DIGITS;
    endtask

    // advance the identifier state by one character; on the last one queue the result
    task automatic scan_char(input logic [CH_W-1:0] c, input logic fin);
        logic    is_alpha;
        logic    is_num;
        logic    is_dollar;
        logic    ok;
        result_t r;
        is_alpha = (c >= CH_UPPER_A && c <= CH_UPPER_Z)
                || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
        is_num = (c >= CH_ZERO && c <= CH_NINE);
        is_dollar = (c == CH_DOLLAR);
        if (!bad) begin
            case (ph)
                PH_START:
                    if (is_dollar)
                    begin
                        dol_col = 1'b1;
                        ph = PH_COL_DOLLAR;
                    end
                    else if (is_alpha)
                        add_letter(c);
                    else
                        bad = 1'b1;
                PH_COL_DOLLAR:
                    if (is_alpha)
                        add_letter(c);
                    else
                        bad = 1'b1;
                PH_LETTERS:
                    if (is_alpha)
                        add_letter(c);
                    else if (is_dollar)
                    begin
                        dol_row = 1'b1;
                        ph = PH_ROW_DOLLAR;
                    end
                    else if (is_num && c != CH_ZERO)
                        add_digit(c);
                    else
                        bad = 1'b1;
                PH_ROW_DOLLAR:
                    if (is_num && c != CH_ZERO)
                        add_digit(c);
                    else
                        bad = 1'b1;
                PH_DIGITS:
                    if (is_num)
                        add_digit(c);
                    else
                        bad = 1'b1;
                default:
                    bad = 1'b1;
            endcase
        end
        if (!fin)
            return;
        ok = !bad && ph == PH_DIGITS && !row_ovf && row_acc >= 1 && row_acc <= row_lim
             && col_acc >= 1 && col_acc <= col_lim;
        r.valid_res = ok;
        r.row = ok ? row_acc : '0;
        r.column = ok ? col_acc : '0;
        r.abs_column = ok && dol_col;
        r.abs_row = ok && dol_row;
        expected_refs.insert(expected_refs.size(), r);
        clear_ident();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_ident();
            row_lim = MAX_ROW_RST;
            col_lim = MAX_COL_RST;
            expected_refs.delete();
            errs = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_refs.size() == 0)
                begin
                    $error("result item with nothing expected");
                    errs++;
                end
                else
                begin
                    want = expected_refs.pop_front();
                    if (valid_res !== want.valid_res)
                    begin
                        $error("valid_res: expected %0d, got %0d", want.valid_res, valid_res);
                        errs++;
                    end
                    if (row !== want.row)
                    begin
                        $error("row: expected %0d, got %0d", want.row, row);
                        errs++;
                    end
                    if (column !== want.column)
                    begin
                        $error("column: expected %0d, got %0d", want.column, column);
                        errs++;
                    end
                    if (abs_column !== want.abs_column)
                    begin
                        $error("abs_column: expected %0d, got %0d", want.abs_column, abs_column);
                        errs++;
                    end
                    if (abs_row !== want.abs_row)
                    begin
                        $error("abs_row: expected %0d, got %0d", want.abs_row, abs_row);
                        errs++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MAX_ROW)
                    row_lim = cfg_data;
                else if (cfg_index == REG_MAX_COL)
                    col_lim = cfg_data[COL_W-1:0];
            end
            if (in_valid && !in_stall)
                scan_char(ch, last);
        end
        mismatch_count <= errs;
        refs_pending <= expected_refs.size();
    end

endmodule

>>> test/a1_cell_reference_parser_top_tb.sv
// Testbench top for the A1 cell reference parser: drives identifiers, limit
// writes and output stalls, and reports the verdict of the checker.
// Depends on a1crp_pkg, a1_cell_reference_parser_top and a1_cell_reference_parser_check.
`timescale 1ns / 1ps

module a1_cell_reference_parser_top_tb;
    import a1crp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam logic [CH_W-1:0] CASE_BIT = 8'h20;
    localparam int HOLD_LEN = 240;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_COL_NUM = 18278;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [CH_W-1:0]       ch = '0;
    logic                  last = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  valid_res;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      column;
    logic                  abs_column;
    logic                  abs_row;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int refs_pending;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_cnt = 0;
    int items_sent = 0;
    int row_limit = 1048576;
    int col_limit = 16384;
    logic [CH_W-1:0] ident_chars[$];

    always #6 clk = ~clk;

    a1_cell_reference_parser_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ch         (ch),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .valid_res  (valid_res),
        .row        (row),
        .column     (column),
        .abs_column (abs_column),
        .abs_row    (abs_row),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    a1_cell_reference_parser_check ref_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .ch             (ch),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .valid_res      (valid_res),
        .row            (row),
        .column         (column),
        .abs_column     (abs_column),
        .abs_row        (abs_row),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatches),
        .refs_pending   (refs_pending)
    );

    // output stall: random, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt <= 0;
            hold_seen <= 0;
        end
        else if (hold_cnt != 0)
        begin
            out_stall <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_cnt <= HOLD_LEN;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_item(input logic [CH_W-1:0] c, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        last <= fin;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++)
            send_item(t[i], i == t.len() - 1);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        do @(posedge clk); while (refs_pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(input int max_row, input int max_col);
        write_reg(REG_MAX_ROW, CFG_DATA_W'(max_row));
        write_reg(REG_MAX_COL, CFG_DATA_W'(max_col));
        row_limit = max_row;
        col_limit = max_col;
    endtask

    // mostly well-formed references, some near the limits, some broken, some noise
    task automatic fill_ident;
        int kind;
        int num;
        int pos;
        logic long_row;
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] part[$];
        kind = $urandom_range(99);
        long_row = 1'b0;
        ident_chars.delete();
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 6))
            begin
                ident_chars.insert(ident_chars.size(), CH_W'($urandom_range(255)));
            end
            return;
        end
        if ($urandom_range(3) == 0)
            ident_chars.insert(ident_chars.size(), CH_DOLLAR);
        case ($urandom_range(3))
            0: num = $urandom_range(1, 26);
            1: num = $urandom_range(27, 702);
            2: num = $urandom_range(1, MAX_COL_NUM);
            default: num = col_limit - 1 + int'($urandom_range(2));
        endcase
        if (num < 1)
            num = 1;
        if (num > MAX_COL_NUM)
            num = MAX_COL_NUM;
        while (num > 0)
        begin
            b = CH_UPPER_A + CH_W'((num - 1) % 26);
            if ($urandom_range(1))
                b = b | CASE_BIT;
            part.push_front(b);
            num = (num - 1) / 26;
        end
        if ($urandom_range(15) == 0)
            part.push_front(CH_LOWER_A + CH_W'($urandom_range(25)));
        foreach (part[i])
            ident_chars.insert(ident_chars.size(), part[i]);
        part.delete();
        if ($urandom_range(3) == 0)
            ident_chars.insert(ident_chars.size(), CH_DOLLAR);
        case ($urandom_range(4))
            0: num = $urandom_range(1, 9);
            1: num = $urandom_range(10, 1048576);
            2: num = row_limit - 1 + int'($urandom_range(2));
            3: num = int'(ROW_SAT) - int'($urandom_range(9));
            default: long_row = 1'b1;
        endcase
        if (long_row)
        begin
            part.insert(part.size(), CH_ZERO + CH_W'($urandom_range(1, 9)));
            repeat ($urandom_range(7, 9))
            begin
                part.insert(part.size(), CH_ZERO + CH_W'($urandom_range(9)));
            end
        end
        else
        begin
            if (num < 1)
                num = 1;
            if (num > int'(ROW_SAT))
                num = int'(ROW_SAT);
            while (num > 0)
            begin
                part.push_front(CH_ZERO + CH_W'(num % 10));
                num = num / 10;
            end
        end
        foreach (part[i])
            ident_chars.insert(ident_chars.size(), part[i]);
        if (kind < 32)
        begin
            pos = $urandom_range(ident_chars.size() - 1);
            case ($urandom_range(2))
                0: ident_chars[pos] = CH_W'($urandom_range(255));
                1: ident_chars = ident_chars[0:pos];
                default: ident_chars.insert(pos, $urandom_range(1) ? CH_ZERO : CH_DOLLAR);
            endcase
        end
    endtask

    task automatic run_random(input int upto);
        while (items_sent < upto)
        begin
            fill_ident();
            foreach (ident_chars[i])
                send_item(ident_chars[i], i == ident_chars.size() - 1);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits; absolute marks, lowercase, leading zero, four letters,
        // bytes at both ends, row overflow, letters only
        send_text("$a$1");
        send_text("B0");
        send_text("ABCD");
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);
        send_text("A9999999");
        send_text("Q");
        run_random(290);

        drain();
        set_limits(int'(ROW_SAT), 2 ** COL_W - 1);
        send_idle_pct = 86;
        run_random(580);

        drain();
        set_limits(1, 1);
        send_idle_pct = 0;
        stall_pct <= 86;
        run_random(870);

        drain();
        write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
        set_limits(0, 0);
        send_idle_pct = 27;
        stall_pct <= 27;
        run_random(1080);

        // long output hold-off with the input kept busy, then a full pause
        drain();
        set_limits(1048576, MAX_COL_NUM);
        send_idle_pct = 0;
        stall_pct <= 0;
        hold_req <= hold_req + 1;
        run_random(items_sent + 40);
        drain();
        run_random(1400);

        drain();
        set_limits($urandom_range(1, int'(ROW_SAT)), $urandom_range(1, MAX_COL_NUM));
        send_idle_pct = 27;
        stall_pct <= 27;
        run_random(1750);

        drain();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> a1_cell_reference_parser_top.f
sv/a1crp_pkg.sv
sv/a1crp_char_step.sv
sv/a1_cell_reference_parser_top.sv
sv/a1crp_checker.sv
test/a1_cell_reference_parser_check.sv
test/a1_cell_reference_parser_top_tb.sv
